@@ rtl/core/csort_pkg.sv @@
// shared constants and types for the cocktail shaker sorter
`default_nettype none

package csort_pkg;

  localparam int Capacity = 64;
  localparam int AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW     = $clog2(Capacity + 1);

  localparam int KeyW  = 32;
  localparam int TagW  = 16;
  localparam int RankW = 6;

  localparam int InDataW  = ((KeyW + TagW + 7) / 8) * 8;
  localparam int OutRawW  = KeyW + TagW + RankW;
  localparam int OutDataW = ((OutRawW + 7) / 8) * 8;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [TagW-1:0]  tag_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef struct packed {
    tag_t tag;
    key_t key;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/cocktail_shaker_sorter.sv @@
// cocktail shaker sorter: store, in-memory shaker passes, ordered read-out
// load: one word per cycle while loading, tready is low during sort and read-out; a word without tlast gives no output
// sort: alternating forward and backward passes over one dual-port ram, each pass shrinking the window by one,
//   stopping early after a pass with no swap
// read-out: one word per cycle while the sink is ready; a stall holds the read word and the output register
// the passes read the ram one entry at a time through its single read port
// reset clears count, overflow flag and control; the store is left as is, no clearing pass
`default_nettype none

module cocktail_shaker_sorter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [csort_pkg::InDataW-1:0]  s_axis_tdata_i,   // sort_key, item_tag
  input  logic                           s_axis_tlast_i,   // batch_end
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [csort_pkg::OutDataW-1:0] m_axis_tdata_o,   // sorted_key, sorted_tag, rank, pad
  output logic                           m_axis_tlast_o,   // final_item
  output logic                           m_axis_tuser_o    // dropped_some
);
  import csort_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FWD,
    ST_BWD,
    ST_EMIT
  } state_e;

  // storage
  entry_t mem_q [Capacity];
  entry_t rdata_q;
  logic   we, re;
  addr_t  waddr, raddr;
  entry_t wdata;

  // control
  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;
  logic   ovf_q, ovf_d;
  cnt_t   lo_q, lo_d;
  cnt_t   hi_q, hi_d;
  cnt_t   left_q, left_d;
  addr_t  idx_q, idx_d;
  addr_t  rpos_q, rpos_d;
  logic   rvalid_q, rvalid_d;
  logic   first_q, first_d;
  logic   swap_q, swap_d;
  entry_t carry_q, carry_d;

  // output register
  logic        m_valid_q, m_valid_d;
  entry_t      m_entry_q, m_entry_d;
  logic [RankW-1:0] m_rank_q, m_rank_d;
  logic        m_last_q, m_last_d;
  logic        m_drop_q, m_drop_d;

  logic   accept;
  logic   stored;
  cnt_t   n_new;
  cnt_t   span;
  logic   consume;
  logic   issue;
  entry_t in_entry;

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign in_entry.key    = s_axis_tdata_i[KeyW-1:0];
  assign in_entry.tag    = s_axis_tdata_i[KeyW+TagW-1:KeyW];
  assign span            = hi_q - lo_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    left_d    = left_q;
    idx_d     = idx_q;
    rpos_d    = rpos_q;
    rvalid_d  = 1'b0;
    first_d   = first_q;
    swap_d    = swap_q;
    carry_d   = carry_q;
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    m_entry_d = m_entry_q;
    m_rank_d  = m_rank_q;
    m_last_d  = m_last_q;
    m_drop_d  = m_drop_q;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = carry_q;
    re        = 1'b0;
    raddr     = idx_q;
    stored    = 1'b0;
    n_new     = cnt_q;
    consume   = 1'b0;
    issue     = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_q < CntW'(Capacity)) begin
            we     = 1'b1;
            waddr  = cnt_q[AddrW-1:0];
            wdata  = in_entry;
            stored = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          n_new = cnt_q + CntW'(stored);
          cnt_d = n_new;
          if (s_axis_tlast_i) begin
            lo_d    = '0;
            hi_d    = n_new;
            idx_d   = '0;
            left_d  = n_new;
            first_d = 1'b1;
            swap_d  = 1'b0;
            if (n_new >= CntW'(2)) begin
              state_d = ST_FWD;
            end else begin
              state_d = ST_EMIT;
            end
          end
        end
      end

      ST_FWD: begin
        if (left_q != '0) begin
          re       = 1'b1;
          raddr    = idx_q;
          idx_d    = idx_q + AddrW'(1);
          left_d   = left_q - CntW'(1);
          rpos_d   = idx_q;
          rvalid_d = 1'b1;
        end
        if (rvalid_q) begin
          if (first_q) begin
            carry_d = rdata_q;
            first_d = 1'b0;
          end else begin
            we    = 1'b1;
            waddr = rpos_q - AddrW'(1);
            // later key strictly smaller moves down, otherwise the later entry becomes the carried maximum
            if (rdata_q.key < carry_q.key) begin
              wdata  = rdata_q;
              swap_d = 1'b1;
            end else begin
              wdata   = carry_q;
              carry_d = rdata_q;
            end
          end
        end else if (left_q == '0) begin
          // pass done: park the maximum at the top
          we      = 1'b1;
          waddr   = AddrW'(hi_q - CntW'(1));
          wdata   = carry_q;
          hi_d    = hi_q - CntW'(1);
          first_d = 1'b1;
          swap_d  = 1'b0;
          if (swap_q && span >= CntW'(3)) begin
            state_d = ST_BWD;
            idx_d   = AddrW'(hi_q - CntW'(2));
            left_d  = span - CntW'(1);
          end else begin
            state_d = ST_EMIT;
            idx_d   = '0;
            left_d  = cnt_q;
          end
        end
      end

      ST_BWD: begin
        if (left_q != '0) begin
          re       = 1'b1;
          raddr    = idx_q;
          idx_d    = idx_q - AddrW'(1);
          left_d   = left_q - CntW'(1);
          rpos_d   = idx_q;
          rvalid_d = 1'b1;
        end
        if (rvalid_q) begin
          if (first_q) begin
            carry_d = rdata_q;
            first_d = 1'b0;
          end else begin
            we    = 1'b1;
            waddr = rpos_q + AddrW'(1);
            // carried minimum passes an earlier entry only when strictly smaller
            if (carry_q.key < rdata_q.key) begin
              wdata  = rdata_q;
              swap_d = 1'b1;
            end else begin
              wdata   = carry_q;
              carry_d = rdata_q;
            end
          end
        end else if (left_q == '0) begin
          we      = 1'b1;
          waddr   = lo_q[AddrW-1:0];
          wdata   = carry_q;
          lo_d    = lo_q + CntW'(1);
          first_d = 1'b1;
          swap_d  = 1'b0;
          if (swap_q && span >= CntW'(3)) begin
            state_d = ST_FWD;
            idx_d   = AddrW'(lo_q + CntW'(1));
            left_d  = span - CntW'(1);
          end else begin
            state_d = ST_EMIT;
            idx_d   = '0;
            left_d  = cnt_q;
          end
        end
      end

      ST_EMIT: begin
        consume = rvalid_q & (~m_valid_q | m_axis_tready_i);
        issue   = (left_q != '0) & (~rvalid_q | consume);
        if (issue) begin
          re     = 1'b1;
          raddr  = idx_q;
          idx_d  = idx_q + AddrW'(1);
          left_d = left_q - CntW'(1);
          rpos_d = idx_q;
        end
        rvalid_d = issue | (rvalid_q & ~consume);
        if (consume) begin
          m_valid_d = 1'b1;
          m_entry_d = rdata_q;
          m_rank_d  = RankW'(rpos_q);
          m_last_d  = ((CntW'(rpos_q) + CntW'(1)) == cnt_q);
          m_drop_d  = ovf_q;
        end
        if (left_q == '0 && !rvalid_q) begin
          state_d = ST_LOAD;
          cnt_d   = '0;
          ovf_d   = 1'b0;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '0;
      left_q    <= '0;
      idx_q     <= '0;
      rpos_q    <= '0;
      rvalid_q  <= 1'b0;
      first_q   <= 1'b0;
      swap_q    <= 1'b0;
      carry_q   <= '0;
      m_valid_q <= 1'b0;
      m_entry_q <= '0;
      m_rank_q  <= '0;
      m_last_q  <= 1'b0;
      m_drop_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      left_q    <= left_d;
      idx_q     <= idx_d;
      rpos_q    <= rpos_d;
      rvalid_q  <= rvalid_d;
      first_q   <= first_d;
      swap_q    <= swap_d;
      carry_q   <= carry_d;
      m_valid_q <= m_valid_d;
      m_entry_q <= m_entry_d;
      m_rank_q  <= m_rank_d;
      m_last_q  <= m_last_d;
      m_drop_q  <= m_drop_d;
    end
  end

  // simple dual-port store, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - OutRawW){1'b0}}, m_rank_q, m_entry_q.tag, m_entry_q.key};
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_drop_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity))
    else $error("item count above capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == CntW'(Capacity)))
    else $error("overflow flagged with room left");

  a_pass_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FWD || state_q == ST_BWD) |-> (lo_q < hi_q && span >= CntW'(2)))
    else $error("pass bounds collapsed");

  a_pass_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && (state_q == ST_FWD || state_q == ST_BWD)) |->
      (CntW'(waddr) < hi_q && CntW'(waddr) >= lo_q))
    else $error("pass write outside active window");

  a_emit_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && rvalid_q) |-> (CntW'(rpos_q) < cnt_q))
    else $error("read-out beyond stored words");
`endif

endmodule

`default_nettype wire
